// ===== rtl/core/pcp_pkg.sv =====
package pcp_pkg;

  typedef enum logic [2:0] {
    REG_STAGE,
    REG_BLACK,
    REG_NORM,
    REG_RED,
    REG_BLUE,
    REG_SAT,
    REG_EXP
  } pcp_reg_e;

  localparam logic [15:0] UNITY_Q12 = 16'd4096;
  localparam logic [15:0] UNITY_Q8  = 16'd256;

  // effective settings after the stage selector has been applied
  typedef struct packed {
    logic [11:0]        black;
    logic [15:0]        norm_gain;
    logic [15:0]        red_gain;
    logic [15:0]        blue_gain;
    logic signed [15:0] sat_gain;
    logic [15:0]        exp_gain;
    logic               tone;
    logic               gamma;
    logic               bypass;
  } pcp_cfg_t;

  // largest code c with (c/255)^(11/5) <= idx/2^gbits, exact integers
  function automatic logic [7:0] gamma_code(input int unsigned idx,
                                            input int unsigned gbits);
    logic [159:0] rhs;
    logic [159:0] lhs;
    logic [7:0]   res;
    logic [7:0]   cand;
    rhs = 160'd1;
    for (int k = 0; k < 11; k++) rhs = rhs * 160'd255;
    for (int k = 0; k < 5; k++) rhs = rhs * 160'(idx);
    res = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      cand = res | (8'd1 << b);
      lhs = 160'd1;
      for (int k = 0; k < 11; k++) lhs = lhs * 160'(cand);
      lhs = lhs << (5 * gbits);
      if (lhs <= rhs) res = cand;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/pcp_front_lane.sv =====
module pcp_front_lane #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [7:0]                    code_i,
  input  pcp_pkg::pcp_cfg_t             cfg_i,
  input  logic [15:0]                   gain_i,
  output logic signed [FRAC_BITS+5:0]   v_o
);

  localparam int unsigned VW = FRAC_BITS + 5;
  localparam logic [FRAC_BITS+20:0] SAT_HI = (FRAC_BITS+21)'((1 << VW) - 1);

  logic [FRAC_BITS:0] code2v [256];

  for (genvar c = 0; c < 256; c++) begin : g_lut
    localparam int unsigned V = ((c << FRAC_BITS) + 127) / 255;
    assign code2v[c] = (FRAC_BITS+1)'(V);
  end

  logic [FRAC_BITS+11:0]      bl_wide;
  logic [FRAC_BITS-1:0]       bl_s;
  logic signed [FRAC_BITS+1:0] x_diff;
  logic [FRAC_BITS:0]         x_d, x_q;
  logic [FRAC_BITS+16:0]      p2;
  logic [FRAC_BITS+16:0]      r2;
  logic [VW-1:0]              v2_d, v2_q;
  logic [FRAC_BITS+20:0]      p3;
  logic [FRAC_BITS+20:0]      r3;
  logic [VW-1:0]              v3_d, v3_q;

  assign bl_wide = {cfg_i.black, {FRAC_BITS{1'b0}}};
  assign bl_s    = bl_wide[FRAC_BITS+11:12];
  assign x_diff  = $signed({1'b0, code2v[code_i]}) - $signed({2'b00, bl_s});
  assign x_d     = x_diff[FRAC_BITS+1] ? '0 : x_diff[FRAC_BITS:0];

  assign p2   = x_q * cfg_i.norm_gain;
  assign r2   = (p2 + (FRAC_BITS+17)'(2048)) >> 12;
  assign v2_d = ((FRAC_BITS+21)'(r2) > SAT_HI) ? SAT_HI[VW-1:0] : r2[VW-1:0];

  assign p3   = v2_q * gain_i;
  assign r3   = (p3 + (FRAC_BITS+21)'(2048)) >> 12;
  assign v3_d = (r3 > SAT_HI) ? SAT_HI[VW-1:0] : r3[VW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign v_o = $signed({1'b0, v3_q});

endmodule

// ===== rtl/core/pcp_luma_merge.sv =====
module pcp_luma_merge #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+5:0] v_r_i,
  input  logic signed [FRAC_BITS+5:0] v_g_i,
  input  logic signed [FRAC_BITS+5:0] v_b_i,
  output logic signed [FRAC_BITS+5:0] luma_o
);

  localparam int unsigned W  = FRAC_BITS + 6;
  localparam int unsigned PW = W + FRAC_BITS + 2;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned CR = ((2126 << FRAC_BITS) + 5000) / 10000;
  localparam int unsigned CB = ((722 << FRAC_BITS) + 5000) / 10000;
  localparam int unsigned CG = (1 << FRAC_BITS) - CR - CB;
  localparam logic signed [FRAC_BITS+1:0] WR = (FRAC_BITS+2)'(CR);
  localparam logic signed [FRAC_BITS+1:0] WG = (FRAC_BITS+2)'(CG);
  localparam logic signed [FRAC_BITS+1:0] WB = (FRAC_BITS+2)'(CB);
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (FRAC_BITS + 5)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sd1 <<< (FRAC_BITS + 5));
  localparam logic signed [SW-1:0] HALF   = SW'(64'sd1 <<< (FRAC_BITS - 1));

  logic signed [PW-1:0] p_r_q, p_g_q, p_b_q;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] rnd;
  logic signed [W-1:0]  luma_d, luma_q;

  assign sum = SW'(p_r_q) + SW'(p_g_q) + SW'(p_b_q);
  assign rnd = (sum + HALF) >>> FRAC_BITS;

  always_comb begin
    if (rnd > SAT_HI)      luma_d = SAT_HI[W-1:0];
    else if (rnd < SAT_LO) luma_d = SAT_LO[W-1:0];
    else                   luma_d = rnd[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_r_q  <= v_r_i * WR;
      p_g_q  <= v_g_i * WG;
      p_b_q  <= v_b_i * WB;
      luma_q <= luma_d;
    end
  end

  assign luma_o = luma_q;

endmodule

// ===== rtl/core/pcp_back_lane.sv =====
module pcp_back_lane #(
  parameter int unsigned FRAC_BITS        = 12,
  parameter int unsigned GAMMA_INDEX_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+5:0] v_i,
  input  logic signed [FRAC_BITS+5:0] luma_i,
  input  pcp_pkg::pcp_cfg_t           cfg_i,
  output logic [7:0]                  code_o
);

  localparam int unsigned W     = FRAC_BITS + 6;
  localparam int unsigned TW    = W + 17;
  localparam int unsigned UW    = FRAC_BITS + 5;
  localparam int unsigned RW    = FRAC_BITS + 6;
  localparam int unsigned GSIZE = 1 << GAMMA_INDEX_BITS;
  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (FRAC_BITS + 5)) - 1);
  localparam logic signed [TW-1:0] SAT_LO = -TW'(64'sd1 <<< (FRAC_BITS + 5));
  localparam logic [RW-1:0] ONE_R = RW'(1 << FRAC_BITS);

  typedef logic [7:0] rom_t [GSIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < GSIZE; i++) r[i] = pcp_pkg::gamma_code(i, GAMMA_INDEX_BITS);
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic signed [W-1:0]  v_d1_q, v_d2_q;
  logic signed [W:0]    diff;
  logic signed [W+16:0] prod6_q;
  logic signed [W-1:0]  luma6_q;
  logic signed [TW-1:0] t7;
  logic signed [W-1:0]  v7_d, v7_q;
  logic signed [W+16:0] e8_q;
  logic signed [TW-1:0] r9;
  logic [UW-1:0]        u9_d, u9_q;

  assign diff = (W+1)'(v_d2_q) - (W+1)'(luma_i);

  assign t7 = TW'(luma6_q) + TW'((prod6_q + (W+17)'(2048)) >>> 12);
  always_comb begin
    if (t7 > SAT_HI)      v7_d = SAT_HI[W-1:0];
    else if (t7 < SAT_LO) v7_d = SAT_LO[W-1:0];
    else                  v7_d = t7[W-1:0];
  end

  // drop negatives here: the output side only sees values at or above zero
  assign r9 = (TW'(e8_q) + TW'(128)) >>> 8;
  always_comb begin
    if (r9 < 0)           u9_d = '0;
    else if (r9 > SAT_HI) u9_d = SAT_HI[UW-1:0];
    else                  u9_d = r9[UW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_d1_q  <= v_i;
      v_d2_q  <= v_d1_q;
      prod6_q <= diff * cfg_i.sat_gain;
      luma6_q <= luma_i;
      v7_q    <= v7_d;
      e8_q    <= v7_q * $signed({1'b0, cfg_i.exp_gain});
      u9_q    <= u9_d;
    end
  end

  // tone map v/(1+v): one quotient bit per stage, restoring
  logic [RW-1:0]        rem_q [FRAC_BITS];
  logic [RW-1:0]        dvs_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS];
  logic [UW-1:0]        u_q   [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [RW-1:0]        rem_in, dvs_in;
    logic [FRAC_BITS-1:0] quo_in;
    logic [UW-1:0]        u_in;
    logic [RW:0]          trial;
    logic                 hit;

    if (k == 0) begin : g_first
      assign rem_in = RW'(u9_q);
      assign dvs_in = RW'(u9_q) + ONE_R;
      assign quo_in = '0;
      assign u_in   = u9_q;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign quo_in = quo_q[k-1];
      assign u_in   = u_q[k-1];
    end

    assign trial = {rem_in, 1'b0};
    assign hit   = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= hit ? RW'(trial - {1'b0, dvs_in}) : trial[RW-1:0];
        dvs_q[k] <= dvs_in;
        quo_q[k] <= {quo_in[FRAC_BITS-2:0], hit};
        u_q[k]   <= u_in;
      end
    end
  end

  logic [UW-1:0]                          tv;
  logic                                   ge_one;
  logic [FRAC_BITS+GAMMA_INDEX_BITS-1:0]  idx_wide;
  logic [GAMMA_INDEX_BITS-1:0]            idx;
  logic [FRAC_BITS+12:0]                  lin_mul;
  logic [12:0]                            lin_code;
  logic [7:0]                             lin_d, lin_q, rom_q;
  logic                                   ge_one_q;

  assign tv       = cfg_i.tone ? UW'(quo_q[FRAC_BITS-1]) : u_q[FRAC_BITS-1];
  assign ge_one   = |tv[UW-1:FRAC_BITS];
  assign idx_wide = {tv[FRAC_BITS-1:0], {GAMMA_INDEX_BITS{1'b0}}};
  assign idx      = idx_wide[FRAC_BITS+GAMMA_INDEX_BITS-1:FRAC_BITS];
  assign lin_mul  = tv * 8'd255;
  assign lin_code = 13'(lin_mul >> FRAC_BITS);
  assign lin_d    = (lin_code > 13'd255) ? 8'd255 : lin_code[7:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rom_q    <= ROM[idx];
      ge_one_q <= ge_one;
      lin_q    <= lin_d;
    end
  end

  assign code_o = cfg_i.gamma ? (ge_one_q ? 8'd255 : rom_q) : lin_q;

endmodule

// ===== rtl/core/preview_color_pipeline_core.sv =====
// One pixel per cycle while no valid result is stalled at the output; the tone-map
// divider is pipelined one quotient bit per stage and the gamma ROM read is registered.
// A stalled output with a valid result freezes the whole pipeline, so no transaction is dropped.
// Reset clears the valid line and restores the register defaults (all stages on).
module preview_color_pipeline_core #(
  parameter int unsigned FRAC_BITS        = 12,
  parameter int unsigned GAMMA_INDEX_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned LAT = FRAC_BITS + 10;

  logic [3:0]  stage_q;
  logic [11:0] black_q;
  logic [15:0] norm_q, red_q, blue_q, sat_q, exp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 4'd8;
      black_q <= '0;
      norm_q  <= pcp_pkg::UNITY_Q12;
      red_q   <= pcp_pkg::UNITY_Q12;
      blue_q  <= pcp_pkg::UNITY_Q12;
      sat_q   <= pcp_pkg::UNITY_Q12;
      exp_q   <= pcp_pkg::UNITY_Q8;
    end else if (cfg_valid_i) begin
      case (pcp_pkg::pcp_reg_e'(cfg_index_i))
        pcp_pkg::REG_STAGE: stage_q <= cfg_data_i[3:0];
        pcp_pkg::REG_BLACK: black_q <= cfg_data_i[11:0];
        pcp_pkg::REG_NORM:  norm_q  <= cfg_data_i;
        pcp_pkg::REG_RED:   red_q   <= cfg_data_i;
        pcp_pkg::REG_BLUE:  blue_q  <= cfg_data_i;
        pcp_pkg::REG_SAT:   sat_q   <= cfg_data_i;
        pcp_pkg::REG_EXP:   exp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcp_pkg::pcp_cfg_t cfg;

  always_comb begin
    cfg.black     = (stage_q >= 4'd1) ? black_q : '0;
    cfg.norm_gain = (stage_q >= 4'd2) ? norm_q : pcp_pkg::UNITY_Q12;
    cfg.red_gain  = (stage_q >= 4'd4) ? red_q : pcp_pkg::UNITY_Q12;
    cfg.blue_gain = (stage_q >= 4'd4) ? blue_q : pcp_pkg::UNITY_Q12;
    cfg.sat_gain  = (stage_q >= 4'd5) ? $signed(sat_q) : $signed(pcp_pkg::UNITY_Q12);
    cfg.exp_gain  = (stage_q >= 4'd6) ? exp_q : pcp_pkg::UNITY_Q8;
    cfg.tone      = stage_q >= 4'd7;
    cfg.gamma     = stage_q >= 4'd8;
    cfg.bypass    = (cfg.black == '0) && (cfg.norm_gain == pcp_pkg::UNITY_Q12) &&
                    (cfg.red_gain == pcp_pkg::UNITY_Q12) &&
                    (cfg.blue_gain == pcp_pkg::UNITY_Q12) &&
                    (cfg.sat_gain == $signed(pcp_pkg::UNITY_Q12)) &&
                    (cfg.exp_gain == pcp_pkg::UNITY_Q8) && !cfg.tone && !cfg.gamma;
  end

  logic en;
  logic vld_q [LAT];
  logic [31:0] pix_q [LAT];

  // hold everything while the result waits
  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[0] <= {alpha_in_i, blue_in_i, green_in_i, red_in_i};
      for (int k = 1; k < LAT; k++) pix_q[k] <= pix_q[k-1];
    end
  end

  logic [7:0]                 codes [3];
  logic [15:0]                gains [3];
  logic signed [FRAC_BITS+5:0] v_lane [3];
  logic signed [FRAC_BITS+5:0] luma;
  logic [7:0]                 res [3];

  assign codes[0] = red_in_i;
  assign codes[1] = green_in_i;
  assign codes[2] = blue_in_i;
  assign gains[0] = cfg.red_gain;
  assign gains[1] = pcp_pkg::UNITY_Q12;
  assign gains[2] = cfg.blue_gain;

  for (genvar l = 0; l < 3; l++) begin : g_front
    pcp_front_lane #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clk_i  (clk_i),
      .en_i   (en),
      .code_i (codes[l]),
      .cfg_i  (cfg),
      .gain_i (gains[l]),
      .v_o    (v_lane[l])
    );
  end

  pcp_luma_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_r_i  (v_lane[0]),
    .v_g_i  (v_lane[1]),
    .v_b_i  (v_lane[2]),
    .luma_o (luma)
  );

  for (genvar l = 0; l < 3; l++) begin : g_back
    pcp_back_lane #(
      .FRAC_BITS        (FRAC_BITS),
      .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS)
    ) u_back (
      .clk_i  (clk_i),
      .en_i   (en),
      .v_i    (v_lane[l]),
      .luma_i (luma),
      .cfg_i  (cfg),
      .code_o (res[l])
    );
  end

  assign red_out_o   = cfg.bypass ? pix_q[LAT-1][7:0]   : res[0];
  assign green_out_o = cfg.bypass ? pix_q[LAT-1][15:8]  : res[1];
  assign blue_out_o  = cfg.bypass ? pix_q[LAT-1][23:16] : res[2];
  assign alpha_out_o = pix_q[LAT-1][31:24];

endmodule
